FILE: design/eida_pkg.sv
// Shared types, codes and defaults of the entity id allocator.
package eida_pkg;

  // Default number of ids handed out
  localparam int unsigned MAX_IDS_DEF = 1024;

  // Field widths of the request and response words
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ENT_ID_W = 10;
  localparam int unsigned STATUS_W = 2;

  // Action codes (code 3 is unused and treated as a query)
  localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DESTROY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALIVE = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ENT_ID_W-1:0] entity_id;
  } req_t;

  typedef struct packed {
    logic [ENT_ID_W-1:0] result_id;
    logic                is_alive;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

FILE: design/entity_id_allocator_core.sv
// Entity id allocator: free-list LIFO stack and alive marks held in two RAMs.
// Sequence: the request word and both RAM reads are registered when the request is
// taken; the result strobe follows the execute state.
// A new request is not taken while busy; busy is high for the cycle in which
// the RAM read words are modified and written back.
// Reset: synchronous; counters cleared, no RAM clearing pass (ids at or above
// the fresh counter read as dead). The receiver cannot stall the result.
module entity_id_allocator_core #(
  parameter int unsigned MAX_IDS = eida_pkg::MAX_IDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  eida_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output eida_pkg::rsp_t rsp
);

  localparam int unsigned ID_W  = $clog2(MAX_IDS);
  localparam int unsigned CNT_W = $clog2(MAX_IDS + 1);
  localparam int unsigned CMP_W = (CNT_W > eida_pkg::ENT_ID_W) ? CNT_W : eida_pkg::ENT_ID_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t           state;
  eida_pkg::req_t   req_q;
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] stack_count_next;
  logic [CNT_W-1:0] next_fresh;
  logic [CNT_W-1:0] next_fresh_next;
  eida_pkg::rsp_t   rsp_next;

  logic             accept;
  logic             alive_rd;
  logic             alive_we;
  logic [ID_W-1:0]  alive_waddr;
  logic             alive_wdata;
  logic [ID_W-1:0]  stack_rd;
  logic             stack_we;
  logic             id_alive;
  logic [ID_W-1:0]  got;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_EXEC);

  // Alive marks, addressed by the incoming id
  eida_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_alive (
    .clk   (clk),
    .we    (alive_we),
    .waddr (alive_waddr),
    .wdata (alive_wdata),
    .raddr (ID_W'(req.entity_id)),
    .rdata (alive_rd)
  );

  // Free stack, read at the top slot, pushed at the count
  eida_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (ID_W'(stack_count)),
    .wdata (ID_W'(req_q.entity_id)),
    .raddr (ID_W'(stack_count - CNT_W'(1))),
    .rdata (stack_rd)
  );

  // An id never reached by the fresh counter has never been marked alive
  assign id_alive = (CMP_W'(req_q.entity_id) < CMP_W'(next_fresh)) && alive_rd;

  // Modify the read words and form the result
  always_comb begin
    stack_count_next = stack_count;
    next_fresh_next  = next_fresh;
    alive_we         = 1'b0;
    alive_waddr      = ID_W'(req_q.entity_id);
    alive_wdata      = 1'b0;
    stack_we         = 1'b0;
    got              = stack_rd;
    rsp_next.result_id = req_q.entity_id;
    rsp_next.is_alive  = 1'b0;
    rsp_next.status    = eida_pkg::STATUS_NOT_ALIVE;
    case (req_q.action)
      eida_pkg::ACT_CREATE: begin
        if (stack_count != '0) begin
          got              = stack_rd;
          stack_count_next = stack_count - CNT_W'(1);
        end else begin
          got              = ID_W'(next_fresh);
          next_fresh_next  = next_fresh + CNT_W'(1);
        end
        if ((stack_count != '0) || (next_fresh < CNT_W'(MAX_IDS))) begin
          alive_we           = busy;
          alive_waddr        = got;
          alive_wdata        = 1'b1;
          rsp_next.result_id = eida_pkg::ENT_ID_W'(got);
          rsp_next.is_alive  = 1'b1;
          rsp_next.status    = eida_pkg::STATUS_OK;
        end else begin
          next_fresh_next    = next_fresh;
          rsp_next.result_id = '0;
          rsp_next.status    = eida_pkg::STATUS_FULL;
        end
      end
      eida_pkg::ACT_DESTROY: begin
        if (id_alive) begin
          alive_we        = busy;
          alive_wdata     = 1'b0;
          rsp_next.status = eida_pkg::STATUS_OK;
          if (stack_count < CNT_W'(MAX_IDS)) begin
            stack_we         = busy;
            stack_count_next = stack_count + CNT_W'(1);
          end
        end
      end
      default: begin
        if (id_alive) begin
          rsp_next.is_alive = 1'b1;
          rsp_next.status   = eida_pkg::STATUS_OK;
        end
      end
    endcase
  end

  // Sequence: take the request, then write back and strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      stack_count <= '0;
      next_fresh  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state       <= ST_IDLE;
          done        <= 1'b1;
          stack_count <= stack_count_next;
          next_fresh  <= next_fresh_next;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the request word and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: design/eida_ram.sv
// Simple dual-port synchronous RAM with registered read.
module eida_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = eida_pkg::MAX_IDS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/eida_checker.sv
// Port-level checker for the entity id allocator, bound to the top level.
module eida_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input eida_pkg::req_t req,
  input logic           busy,
  input logic           done,
  input eida_pkg::rsp_t rsp
);

  // Take a word only when idle, then go busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken without going busy");

  // Busy lasts one cycle and is followed by the result strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy not followed by a single result strobe");

  // Strobe only after a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding request");

  // Full and dead results never report an alive id
  a_fail_dead: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == eida_pkg::STATUS_FULL ||
             rsp.status == eida_pkg::STATUS_NOT_ALIVE) |-> !rsp.is_alive)
    else $error("failed result reports an alive id");

  // Full result carries id zero
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == eida_pkg::STATUS_FULL |-> rsp.result_id == '0)
    else $error("full result carries a non-zero id");

endmodule

bind entity_id_allocator_core eida_checker u_eida_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .req   (req),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

FILE: dv/testbench.sv
// Self-checking testbench for the entity id allocator core.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IDS = eida_pkg::MAX_IDS_DEF;
  localparam int unsigned IDX_W = $clog2(IDS);
  // Unused action code; the block treats it as a query
  localparam logic [eida_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  eida_pkg::req_t req = '0;
  logic busy;
  logic done;
  eida_pkg::rsp_t rsp;

  entity_id_allocator_core dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow allocator state
  bit                          live_mark [0:IDS-1];
  bit [eida_pkg::ENT_ID_W-1:0] free_ids [0:IDS-1];
  int unsigned                 free_cnt = 0;
  int unsigned                 fresh_cnt = 0;

  eida_pkg::req_t pend_q [$];
  eida_pkg::rsp_t alloc_q [$];
  int   errors = 0;
  int   n_create = 0, n_full = 0, n_destroy = 0, n_query = 0;

  // Work out the response word for one request and update the shadow state
  function automatic eida_pkg::rsp_t alloc_predict(eida_pkg::req_t r);
    eida_pkg::rsp_t o;
    int unsigned    got;
    o.result_id = r.entity_id;
    o.is_alive  = 1'b0;
    o.status    = eida_pkg::STATUS_NOT_ALIVE;
    if (r.action == eida_pkg::ACT_CREATE) begin
      n_create++;
      if (free_cnt > 0) begin
        free_cnt--;
        got = 32'(free_ids[IDX_W'(free_cnt)]);
      end else if (fresh_cnt < IDS) begin
        got = fresh_cnt;
        fresh_cnt++;
      end else begin
        n_full++;
        o.result_id = '0;
        o.status    = eida_pkg::STATUS_FULL;
        return o;
      end
      live_mark[IDX_W'(got)] = 1'b1;
      o.result_id = eida_pkg::ENT_ID_W'(got);
      o.is_alive  = 1'b1;
      o.status    = eida_pkg::STATUS_OK;
    end else if (r.action == eida_pkg::ACT_DESTROY) begin
      n_destroy++;
      if (live_mark[r.entity_id]) begin
        live_mark[r.entity_id] = 1'b0;
        free_ids[IDX_W'(free_cnt)] = r.entity_id;
        free_cnt++;
        o.status = eida_pkg::STATUS_OK;
      end
    end else begin
      n_query++;
      if (live_mark[r.entity_id]) begin
        o.is_alive = 1'b1;
        o.status   = eida_pkg::STATUS_OK;
      end
    end
    return o;
  endfunction

  // Driver: present queued words in bursts with random gaps
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : drive_p
    logic           take;
    logic           nstart;
    eida_pkg::req_t nreq;
    eida_pkg::req_t cur;
    take   = start && !busy;
    nstart = start;
    nreq   = req;
    if (rst) begin
      nstart = 1'b0;
    end else begin
      // Hand the taken word to the predictor and pick a new burst length
      if (take) begin
        cur = pend_q.pop_front();
        alloc_q.insert(alloc_q.size(), alloc_predict(cur));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
      // Hold a word not yet taken; otherwise idle out the gap or advance
      if (!start || take) begin
        if (gap_left > 0) begin
          gap_left--;
          nstart = 1'b0;
        end else if (pend_q.size() != 0) begin
          nstart = 1'b1;
          nreq   = pend_q[0];
        end else begin
          nstart = 1'b0;
        end
      end
    end
    start <= nstart;
    req   <= nreq;
  end

  // Monitor: check each response word against the oldest prediction
  always @(posedge clk) begin : check_p
    eida_pkg::rsp_t want;
    if (!rst && done) begin
      if (alloc_q.size() == 0) begin
        $error("response word with nothing pending: id %0d alive %0d status %0d",
               rsp.result_id, rsp.is_alive, rsp.status);
        errors++;
      end else begin
        want = alloc_q.pop_front();
        if (rsp.result_id !== want.result_id) begin
          $error("result_id: expected %0d, got %0d", want.result_id, rsp.result_id);
          errors++;
        end
        if (rsp.is_alive !== want.is_alive) begin
          $error("is_alive: expected %0d, got %0d", want.is_alive, rsp.is_alive);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          errors++;
        end
      end
    end
  end

  task automatic push_req(logic [eida_pkg::ACTION_W-1:0] act,
                          logic [eida_pkg::ENT_ID_W-1:0] id);
    eida_pkg::req_t r;
    r.action    = act;
    r.entity_id = id;
    pend_q.insert(pend_q.size(), r);
  endtask

  // Wait until every queued word is taken and every response has come back
  task automatic wait_idle();
    while (pend_q.size() != 0 || alloc_q.size() != 0) @(negedge clk);
  endtask

  // Pick an id that is often one handed out so far, sometimes any id
  function automatic logic [eida_pkg::ENT_ID_W-1:0] pick_id();
    if (fresh_cnt > 0 && $urandom_range(0, 3) != 0)
      return eida_pkg::ENT_ID_W'($urandom_range(0, fresh_cnt - 1));
    return eida_pkg::ENT_ID_W'($urandom);
  endfunction

  // Queue mixed requests in short batches, re-reading the shadow state each time
  task automatic push_mix(int n);
    int k;
    for (k = 0; k < n; k++) begin
      if (k % 16 == 0) wait_idle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_req(eida_pkg::ACT_CREATE, eida_pkg::ENT_ID_W'($urandom));
        4, 5, 6:    push_req(eida_pkg::ACT_DESTROY, pick_id());
        7, 8:       push_req(eida_pkg::ACT_QUERY, pick_id());
        default:    push_req(ACT_SPARE, pick_id());
      endcase
    end
  endtask

  initial begin : stim_p
    int need;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty allocator, LIFO reuse, dead and unknown ids, spare code
    push_req(eida_pkg::ACT_QUERY, 10'd0);
    push_req(eida_pkg::ACT_DESTROY, 10'd0);
    push_req(eida_pkg::ACT_CREATE, 10'd1023);
    push_req(eida_pkg::ACT_CREATE, 10'd0);
    push_req(eida_pkg::ACT_QUERY, 10'd0);
    push_req(eida_pkg::ACT_QUERY, 10'd1023);
    push_req(eida_pkg::ACT_DESTROY, 10'd1);
    push_req(eida_pkg::ACT_DESTROY, 10'd1);
    push_req(eida_pkg::ACT_QUERY, 10'd1);
    push_req(eida_pkg::ACT_CREATE, 10'd682);
    push_req(eida_pkg::ACT_DESTROY, 10'd0);
    push_req(eida_pkg::ACT_DESTROY, 10'd1);
    push_req(eida_pkg::ACT_CREATE, 10'd341);
    push_req(eida_pkg::ACT_CREATE, 10'd0);
    push_req(eida_pkg::ACT_CREATE, 10'd0);
    push_req(ACT_SPARE, 10'd2);
    push_req(ACT_SPARE, 10'd1000);
    push_req(eida_pkg::ACT_DESTROY, 10'd1023);
    push_req(eida_pkg::ACT_QUERY, 10'd512);
    push_req(eida_pkg::ACT_DESTROY, 10'd2);
    push_req(eida_pkg::ACT_QUERY, 10'd2);

    // Random traffic from a sparse allocator
    push_mix(64);

    // Drain the free list and the fresh counter, then run past the end
    wait_idle();
    need = int'(free_cnt + (IDS - fresh_cnt) + 3);
    repeat (need) push_req(eida_pkg::ACT_CREATE, eida_pkg::ENT_ID_W'($urandom));
    push_req(eida_pkg::ACT_QUERY, 10'd1023);
    push_req(eida_pkg::ACT_DESTROY, 10'd1023);
    push_req(eida_pkg::ACT_CREATE, 10'd0);
    push_req(eida_pkg::ACT_CREATE, 10'd0);

    // Random traffic from a full allocator
    push_mix(96);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d creates (%0d with no id left), %0d destroys, %0d queries",
             n_create, n_full, n_destroy, n_query);
    $display("Mismatches and stray responses: %0d", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
